>>> src/unicycle_pose_rollout_with_goal_distance_assert.svh
// Assertion macros shared by the rollout block.
// Each macro takes a label, clock, active-low reset, a condition and a consequence.
`ifndef UNICYCLE_POSE_ROLLOUT_WITH_GOAL_DISTANCE_ASSERT_SVH
`define UNICYCLE_POSE_ROLLOUT_WITH_GOAL_DISTANCE_ASSERT_SVH
`ifndef SYNTH
`define UPR_ASSERT_SAME(name, clk, rst_n, cond, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (cons)) \
        else $error("same-cycle implication failed");
`define UPR_ASSERT_NEXT(name, clk, rst_n, cond, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (cons)) \
        else $error("next-cycle implication failed");
`else
`define UPR_ASSERT_SAME(name, clk, rst_n, cond, cons)
`define UPR_ASSERT_NEXT(name, clk, rst_n, cond, cons)
`endif
`endif

>>> src/upr_pkg.sv
`default_nettype none
package upr_pkg;

    // 2^32 / (2*pi), rounded.
    localparam logic [29:0] INV_TWO_PI_Q32 = 30'd683565276;
    // CORDIC start vector, the inverse of the limit gain in Q1.30.
    localparam logic signed [33:0] CORDIC_START = 34'sd652032874;
    localparam int MAX_STAGES = 24;

    typedef enum logic [2:0] {
        CFG_STEP_TIME     = 3'd0,
        CFG_START_X       = 3'd1,
        CFG_START_Y       = 3'd2,
        CFG_START_HEADING = 3'd3,
        CFG_GOAL_X        = 3'd4,
        CFG_GOAL_Y        = 3'd5
    } t_cfg_idx;

    typedef enum logic [2:0] {
        S_IDLE,
        S_CORDIC,
        S_MUL,
        S_ACC,
        S_SQRT,
        S_DONE
    } t_state;

    // Multiplier operations, in the order the sequencer runs them.
    typedef enum logic [2:0] {
        OP_V,
        OP_X,
        OP_Y,
        OP_R,
        OP_H,
        OP_A,
        OP_B
    } t_op;

    typedef struct packed {
        logic capture;
        logic cordic_step;
        logic mul_en;
        logic acc_en;
        t_op  op;
        logic sqrt_step;
        logic out_write;
    } t_cmd;

    typedef struct packed {
        logic cordic_last;
        logic sqrt_last;
    } t_sts;

    // Arctangent of 2^-i as a fraction of a turn, 2^32 per turn.
    function automatic logic [31:0] upr_atan(input logic [4:0] idx);
        logic [31:0] v;
        begin
            case (idx)
                5'd0:  v = 32'd536870912;
                5'd1:  v = 32'd316933406;
                5'd2:  v = 32'd167458907;
                5'd3:  v = 32'd85004756;
                5'd4:  v = 32'd42667331;
                5'd5:  v = 32'd21354465;
                5'd6:  v = 32'd10679838;
                5'd7:  v = 32'd5340245;
                5'd8:  v = 32'd2670163;
                5'd9:  v = 32'd1335087;
                5'd10: v = 32'd667544;
                5'd11: v = 32'd333772;
                5'd12: v = 32'd166886;
                5'd13: v = 32'd83443;
                5'd14: v = 32'd41722;
                5'd15: v = 32'd20861;
                5'd16: v = 32'd10430;
                5'd17: v = 32'd5215;
                5'd18: v = 32'd2608;
                5'd19: v = 32'd1304;
                5'd20: v = 32'd652;
                5'd21: v = 32'd326;
                5'd22: v = 32'd163;
                5'd23: v = 32'd81;
                default: v = 32'd0;
            endcase
            return v;
        end
    endfunction

endpackage
`default_nettype wire

>>> src/unicycle_pose_rollout_with_goal_distance.sv
// Unicycle pose rollout: each accepted request (linear speed, turn rate, last-step
// flag) advances the pose by one Euler step using the heading from before the step,
// and returns the new x, y (Q16.16, wrapping), heading (16-bit binary angle) and the
// floor distance to the goal point (Q16.16, saturating to all ones). The first request
// after reset or after a request marked last starts from the configured start pose.
// Each request runs CORDIC_STAGES (capped at 24) steps of a CORDIC rotator, then its
// products on one shared 33x33 multiplier, then a bit-serial square root and a final
// step to post the result. A new request is taken only once the previous result
// has been posted. A finished result waits in an output register, so the next request
// is taken while it is still stalled. Configuration writes must go in only while
// idle; the block itself does not enforce this.
`default_nettype none
`include "unicycle_pose_rollout_with_goal_distance_assert.svh"
module unicycle_pose_rollout_with_goal_distance #(
    parameter int ANGLE_BITS    = 16,
    parameter int CORDIC_STAGES = 16
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_cfg_we,
    input  wire logic [2:0]         i_cfg_index,
    input  wire logic [31:0]        i_cfg_data,
    input  wire logic               i_in_valid,
    output logic                    o_in_stall,
    input  wire logic signed [23:0] i_linear_speed,
    input  wire logic signed [23:0] i_turn_rate,
    input  wire logic               i_last_step,
    output logic                    o_out_valid,
    input  wire logic               i_out_stall,
    output logic signed [31:0]      o_pos_x,
    output logic signed [31:0]      o_pos_y,
    output logic [15:0]             o_heading,
    output logic [31:0]             o_goal_distance,
    output logic                    o_rollout_end
);
    import upr_pkg::*;

    t_cmd cmd;
    t_sts sts;

    // The controller sequences CORDIC, multiplier and square root steps.
    upr_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_out_stall (i_out_stall),
        .i_sts       (sts),
        .o_cmd       (cmd),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid)
    );

    // The datapath holds the configuration, the pose and all arithmetic.
    upr_dp #(
        .ANGLE_BITS    (ANGLE_BITS),
        .CORDIC_STAGES (CORDIC_STAGES)
    ) u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (cmd),
        .o_sts           (sts),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data),
        .i_linear_speed  (i_linear_speed),
        .i_turn_rate     (i_turn_rate),
        .i_last_step     (i_last_step),
        .o_pos_x         (o_pos_x),
        .o_pos_y         (o_pos_y),
        .o_heading       (o_heading),
        .o_goal_distance (o_goal_distance),
        .o_rollout_end   (o_rollout_end)
    );

    // A request that is taken keeps the block busy for the following cycle.
    `UPR_ASSERT_NEXT(a_busy_after_accept, i_clk, i_rst_n, i_in_valid && !o_in_stall, o_in_stall)
    // A result is never posted over one that is still stalled.
    `UPR_ASSERT_SAME(a_no_overwrite, i_clk, i_rst_n, cmd.out_write, !(o_out_valid && i_out_stall))
    // A new result only appears after the block has been working.
    `UPR_ASSERT_SAME(a_result_from_work, i_clk, i_rst_n, $rose(o_out_valid), $past(o_in_stall))

endmodule
`default_nettype wire

>>> src/upr_ctrl.sv
`default_nettype none
module upr_ctrl (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_in_valid,
    input  wire logic          i_out_stall,
    input  wire upr_pkg::t_sts i_sts,
    output upr_pkg::t_cmd      o_cmd,
    output logic               o_in_stall,
    output logic               o_out_valid
);
    import upr_pkg::*;

    t_state r_state, n_state;
    t_op    r_op, n_op;
    logic   r_out_valid, n_out_valid;
    logic   slot_free;

    assign slot_free = !r_out_valid || !i_out_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_op        <= OP_V;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_op        <= n_op;
            r_out_valid <= n_out_valid;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE:   if (i_in_valid) n_state = S_CORDIC;
            S_CORDIC: if (i_sts.cordic_last) n_state = S_MUL;
            S_MUL:    n_state = S_ACC;
            S_ACC:    n_state = (r_op == OP_B) ? S_SQRT : S_MUL;
            S_SQRT:   if (i_sts.sqrt_last) n_state = S_DONE;
            S_DONE:   if (slot_free) n_state = S_IDLE;
            default:  n_state = S_IDLE;
        endcase
    end

    always_comb begin
        n_op = r_op;
        if (r_state == S_IDLE) begin
            n_op = OP_V;
        end else if (r_state == S_ACC) begin
            unique case (r_op)
                OP_V:    n_op = OP_X;
                OP_X:    n_op = OP_Y;
                OP_Y:    n_op = OP_R;
                OP_R:    n_op = OP_H;
                OP_H:    n_op = OP_A;
                OP_A:    n_op = OP_B;
                default: n_op = OP_V;
            endcase
        end
    end

    always_comb begin
        o_cmd             = '0;
        o_cmd.op          = r_op;
        o_cmd.capture     = (r_state == S_IDLE) && i_in_valid;
        o_cmd.cordic_step = (r_state == S_CORDIC);
        o_cmd.mul_en      = (r_state == S_MUL);
        o_cmd.acc_en      = (r_state == S_ACC);
        o_cmd.sqrt_step   = (r_state == S_SQRT);
        o_cmd.out_write   = (r_state == S_DONE) && slot_free;
        o_in_stall        = (r_state != S_IDLE);
    end

    always_comb begin
        n_out_valid = r_out_valid && i_out_stall;
        if (o_cmd.out_write) n_out_valid = 1'b1;
    end

    assign o_out_valid = r_out_valid;

endmodule
`default_nettype wire

>>> src/upr_dp.sv
`default_nettype none
module upr_dp #(
    parameter int ANGLE_BITS    = 16,
    parameter int CORDIC_STAGES = 16
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire upr_pkg::t_cmd      i_cmd,
    output upr_pkg::t_sts           o_sts,
    input  wire logic               i_cfg_we,
    input  wire logic [2:0]         i_cfg_index,
    input  wire logic [31:0]        i_cfg_data,
    input  wire logic signed [23:0] i_linear_speed,
    input  wire logic signed [23:0] i_turn_rate,
    input  wire logic               i_last_step,
    output logic signed [31:0]      o_pos_x,
    output logic signed [31:0]      o_pos_y,
    output logic [15:0]             o_heading,
    output logic [31:0]             o_goal_distance,
    output logic                    o_rollout_end
);
    import upr_pkg::*;

    localparam int AB     = ANGLE_BITS;
    localparam int NSTG   = (CORDIC_STAGES < MAX_STAGES) ? CORDIC_STAGES : MAX_STAGES;
    localparam int SH_UP  = (AB >= 16) ? AB - 16 : 0;
    localparam int SH_DN  = (AB < 16) ? 16 - AB : 0;
    localparam int HSH    = 48 - AB;
    localparam logic signed [65:0] HRND = 66'sd1 <<< (HSH - 1);

    // Configuration.
    logic [15:0]        r_step_time, r_start_h;
    logic signed [31:0] r_start_x, r_start_y, r_goal_x, r_goal_y;

    // Pose and item.
    logic signed [31:0]   r_cur_x, r_cur_y;
    logic [AB-1:0]        r_cur_h;
    logic                 r_in_rollout;
    logic signed [23:0]   r_speed, r_rate;
    logic                 r_last;

    // CORDIC.
    logic signed [33:0] r_cx, r_cy;
    logic signed [32:0] r_cz;
    logic [1:0]         r_quad;
    logic [4:0]         r_iter;

    // Products and intermediates.
    logic signed [65:0] r_prod;
    logic signed [25:0] r_v;
    logic signed [24:0] r_r16;
    logic [63:0]        r_sum;
    logic               r_sat;

    // Square root.
    logic [63:0] r_sq_n;
    logic [34:0] r_rem;
    logic [31:0] r_root;

    logic [AB-1:0]      start_h_int, h_eff;
    logic [39:0]        h_up, h_dn;
    logic [29:0]        z_init;
    logic signed [33:0] shx, shy, cos_v, sin_v;
    logic signed [32:0] atan_v, mul_a, mul_b, dx, dy, dx_abs, dy_abs;
    logic signed [65:0] prod_c;
    logic [64:0]        sum65;
    logic [34:0]        rem_sh, trial;

    // Start heading brought to the internal angle width.
    assign h_up        = ({24'd0, r_start_h} << SH_UP) >> SH_DN;
    assign start_h_int = h_up[AB-1:0];
    assign h_eff       = r_in_rollout ? r_cur_h : start_h_int;
    assign z_init      = {h_eff[AB-3:0], {(32-AB){1'b0}}};
    assign h_dn        = ({{(40-AB){1'b0}}, r_cur_h} << SH_DN) >> SH_UP;

    assign shx    = r_cx >>> r_iter;
    assign shy    = r_cy >>> r_iter;
    assign atan_v = $signed({1'b0, upr_atan(r_iter)});

    always_comb begin
        case (r_quad)
            2'd0:    begin cos_v = r_cx;  sin_v = r_cy;  end
            2'd1:    begin cos_v = -r_cy; sin_v = r_cx;  end
            2'd2:    begin cos_v = -r_cx; sin_v = -r_cy; end
            default: begin cos_v = r_cy;  sin_v = -r_cx; end
        endcase
    end

    assign dx     = 33'(r_goal_x) - 33'(r_cur_x);
    assign dy     = 33'(r_goal_y) - 33'(r_cur_y);
    assign dx_abs = dx[32] ? -dx : dx;
    assign dy_abs = dy[32] ? -dy : dy;

    always_comb begin
        case (i_cmd.op)
            OP_V:    begin mul_a = 33'(r_speed); mul_b = $signed({17'd0, r_step_time}); end
            OP_X:    begin mul_a = 33'(r_v);     mul_b = cos_v[32:0]; end
            OP_Y:    begin mul_a = 33'(r_v);     mul_b = sin_v[32:0]; end
            OP_R:    begin mul_a = 33'(r_rate);  mul_b = $signed({17'd0, r_step_time}); end
            OP_H:    begin mul_a = 33'(r_r16);   mul_b = $signed({3'd0, INV_TWO_PI_Q32}); end
            OP_A:    begin mul_a = dx_abs;       mul_b = dx_abs; end
            default: begin mul_a = dy_abs;       mul_b = dy_abs; end
        endcase
    end

    assign prod_c = 66'(mul_a) * 66'(mul_b);
    assign sum65  = {1'b0, r_sum} + {1'b0, r_prod[63:0]};
    assign rem_sh = {r_rem[32:0], r_sq_n[63:62]};
    assign trial  = {1'b0, r_root, 2'b01};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step_time  <= 16'd655;
            r_start_x    <= 32'sd65536;
            r_start_y    <= 32'sd327680;
            r_start_h    <= 16'd20861;
            r_goal_x     <= 32'sd327680;
            r_goal_y     <= 32'sd655360;
            r_in_rollout <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                unique case (t_cfg_idx'(i_cfg_index))
                    CFG_STEP_TIME:     r_step_time <= i_cfg_data[15:0];
                    CFG_START_X:       r_start_x   <= i_cfg_data;
                    CFG_START_Y:       r_start_y   <= i_cfg_data;
                    CFG_START_HEADING: r_start_h   <= i_cfg_data[15:0];
                    CFG_GOAL_X:        r_goal_x    <= i_cfg_data;
                    CFG_GOAL_Y:        r_goal_y    <= i_cfg_data;
                    default: ;
                endcase
            end
            if (i_cmd.capture) r_in_rollout <= !i_last_step;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_speed <= i_linear_speed;
            r_rate  <= i_turn_rate;
            r_last  <= i_last_step;
            if (!r_in_rollout) begin
                r_cur_x <= r_start_x;
                r_cur_y <= r_start_y;
                r_cur_h <= start_h_int;
            end
            r_cx   <= CORDIC_START;
            r_cy   <= '0;
            r_cz   <= $signed({3'd0, z_init});
            r_quad <= h_eff[AB-1 -: 2];
            r_iter <= '0;
        end
        if (i_cmd.cordic_step) begin
            if (!r_cz[32]) begin
                r_cx <= r_cx - shy;
                r_cy <= r_cy + shx;
                r_cz <= r_cz - atan_v;
            end else begin
                r_cx <= r_cx + shy;
                r_cy <= r_cy - shx;
                r_cz <= r_cz + atan_v;
            end
            r_iter <= r_iter + 5'd1;
        end
        if (i_cmd.mul_en) r_prod <= prod_c;
        if (i_cmd.acc_en) begin
            case (i_cmd.op)
                OP_V: r_v     <= 26'((r_prod + 66'sd8192) >>> 14);
                OP_X: r_cur_x <= r_cur_x + 32'((r_prod + 66'sh80000000) >>> 32);
                OP_Y: r_cur_y <= r_cur_y + 32'((r_prod + 66'sh80000000) >>> 32);
                OP_R: r_r16   <= 25'((r_prod + 66'sd32768) >>> 16);
                OP_H: r_cur_h <= r_cur_h + ANGLE_BITS'((r_prod + HRND) >>> HSH);
                OP_A: r_sum   <= r_prod[63:0];
                default: begin
                    // Sum of squares; a carry out means the distance saturates.
                    r_sat  <= sum65[64];
                    r_sq_n <= sum65[63:0];
                    r_rem  <= '0;
                    r_root <= '0;
                    r_iter <= '0;
                end
            endcase
        end
        if (i_cmd.sqrt_step) begin
            if (rem_sh >= trial) begin
                r_rem  <= rem_sh - trial;
                r_root <= {r_root[30:0], 1'b1};
            end else begin
                r_rem  <= rem_sh;
                r_root <= {r_root[30:0], 1'b0};
            end
            r_sq_n <= {r_sq_n[61:0], 2'b00};
            r_iter <= r_iter + 5'd1;
        end
        if (i_cmd.out_write) begin
            o_pos_x         <= r_cur_x;
            o_pos_y         <= r_cur_y;
            o_heading       <= h_dn[15:0];
            o_goal_distance <= r_sat ? 32'hFFFF_FFFF : r_root;
            o_rollout_end   <= r_last;
        end
    end

    assign o_sts.cordic_last = (r_iter == 5'(NSTG - 1));
    assign o_sts.sqrt_last   = (r_iter == 5'd31);

endmodule
`default_nettype wire

>>> test/tb_unicycle_pose_rollout_with_goal_distance.sv
`timescale 1ns / 1ps
`default_nettype none

// Expected-pose tracker for the unicycle rollout.
// It keeps its own copy of the pose and of the registers, and it predicts one
// result for every request. Results are then compared in order.
class pose_tracker;
    logic [15:0] step_time;
    logic [31:0] start_x;
    logic [31:0] start_y;
    logic [15:0] start_heading;
    logic [31:0] goal_x;
    logic [31:0] goal_y;
    logic [31:0] cur_x;
    logic [31:0] cur_y;
    logic [15:0] cur_heading;
    bit          in_rollout;
    logic [31:0] want_x[$];
    logic [31:0] want_y[$];
    logic [15:0] want_h[$];
    logic [31:0] want_d[$];
    bit          want_e[$];
    int          mismatches;
    int          results_seen;

    function new();
        step_time     = 16'd655;
        start_x       = 32'd65536;
        start_y       = 32'd327680;
        start_heading = 16'd20861;
        goal_x        = 32'd327680;
        goal_y        = 32'd655360;
        cur_x         = '0;
        cur_y         = '0;
        cur_heading   = '0;
        in_rollout    = 0;
        mismatches    = 0;
        results_seen  = 0;
    endfunction

    // Arithmetic right shift that rounds toward minus infinity.
    static function longint shr_floor(longint v, int s);
        return v >>> s;
    endfunction

    static function longint shr_round(longint v, int s);
        return (v + (longint'(1) <<< (s - 1))) >>> s;
    endfunction

    static function longint atan_turn(int i);
        longint tbl[16];
        tbl = '{536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
                10679838, 5340245, 2670163, 1335087, 667544, 333772,
                166886, 83443, 41722, 20861};
        return tbl[i];
    endfunction

    // Rotation CORDIC, quadrant folded first; both results are Q1.30.
    static function void sin_cos(logic [15:0] ang, output longint c, output longint s);
        logic [31:0] a32;
        longint x, y, z, nx;
        a32 = {ang, 16'h0};
        z = longint'(a32[29:0]);
        x = 652032874;
        y = 0;
        for (int i = 0; i < 16; i++) begin
            if (z >= 0) begin
                nx = x - shr_floor(y, i);
                y  = y + shr_floor(x, i);
                z  = z - atan_turn(i);
            end else begin
                nx = x + shr_floor(y, i);
                y  = y - shr_floor(x, i);
                z  = z + atan_turn(i);
            end
            x = nx;
        end
        case (a32[31:30])
            2'd0: begin c = x;  s = y;  end
            2'd1: begin c = -y; s = x;  end
            2'd2: begin c = -x; s = -y; end
            default: begin c = y; s = -x; end
        endcase
    endfunction

    static function logic [31:0] floor_sqrt(logic [63:0] n);
        logic [63:0] r, b;
        r = 0;
        b = 64'h4000_0000_0000_0000;
        while (b > n) b = b >> 2;
        while (b != 0) begin
            if (n >= r + b) begin
                n = n - (r + b);
                r = (r >> 1) + b;
            end else begin
                r = r >> 1;
            end
            b = b >> 2;
        end
        return r[31:0];
    endfunction

    function logic [31:0] goal_range();
        longint dx, dy;
        logic [63:0] a, b, a2, b2;
        dx = longint'($signed(goal_x)) - longint'($signed(cur_x));
        dy = longint'($signed(goal_y)) - longint'($signed(cur_y));
        a = dx < 0 ? -dx : dx;
        b = dy < 0 ? -dy : dy;
        if (a >= 64'h1_0000_0000 || b >= 64'h1_0000_0000) return 32'hFFFF_FFFF;
        a2 = a * a;
        b2 = b * b;
        if (a2 > 64'hFFFF_FFFF_FFFF_FFFF - b2) return 32'hFFFF_FFFF;
        return floor_sqrt(a2 + b2);
    endfunction

    function void write_reg(upr_pkg::t_cfg_idx idx, logic [31:0] data);
        case (idx)
            upr_pkg::CFG_STEP_TIME:     step_time = data[15:0];
            upr_pkg::CFG_START_X:       start_x = data;
            upr_pkg::CFG_START_Y:       start_y = data;
            upr_pkg::CFG_START_HEADING: start_heading = data[15:0];
            upr_pkg::CFG_GOAL_X:        goal_x = data;
            upr_pkg::CFG_GOAL_Y:        goal_y = data;
            default: ;
        endcase
    endfunction

    // Advances the pose by one Euler step and queues the expected result.
    function void note_request(logic [23:0] speed, logic [23:0] rate, bit last);
        longint c, s, v, r16, dh;
        logic [31:0] ix, iy;
        if (!in_rollout) begin
            cur_x = start_x;
            cur_y = start_y;
            cur_heading = start_heading;
        end
        sin_cos(cur_heading, c, s);
        v = shr_round(longint'($signed(speed)) * longint'(step_time), 14);
        ix = 32'(shr_round(v * c, 32));
        iy = 32'(shr_round(v * s, 32));
        cur_x = cur_x + ix;
        cur_y = cur_y + iy;
        r16 = shr_round(longint'($signed(rate)) * longint'(step_time), 16);
        dh = shr_round(r16 * 683565276, 32);
        cur_heading = cur_heading + 16'(dh);
        in_rollout = !last;
        want_x.push_back(cur_x);
        want_y.push_back(cur_y);
        want_h.push_back(cur_heading);
        want_d.push_back(goal_range());
        want_e.push_back(last);
    endfunction

    function void check_result(logic [31:0] x, logic [31:0] y, logic [15:0] h,
                               logic [31:0] d, logic e);
        logic [31:0] ex, ey, ed;
        logic [15:0] eh;
        bit ee;
        results_seen++;
        if (want_x.size() == 0) begin
            $display("%0t: result with no request pending: x=%h y=%h", $time, x, y);
            mismatches++;
            return;
        end
        ex = want_x.pop_front();
        ey = want_y.pop_front();
        eh = want_h.pop_front();
        ed = want_d.pop_front();
        ee = want_e.pop_front();
        if (x !== ex) begin
            $display("%0t: pos_x expected %h actual %h", $time, ex, x);
            mismatches++;
        end
        if (y !== ey) begin
            $display("%0t: pos_y expected %h actual %h", $time, ey, y);
            mismatches++;
        end
        if (h !== eh) begin
            $display("%0t: heading expected %h actual %h", $time, eh, h);
            mismatches++;
        end
        if (d !== ed) begin
            $display("%0t: goal_distance expected %h actual %h", $time, ed, d);
            mismatches++;
        end
        if (e !== ee) begin
            $display("%0t: rollout_end expected %b actual %b", $time, ee, e);
            mismatches++;
        end
    endfunction

    function int pending();
        return want_x.size();
    endfunction
endclass

module tb_unicycle_pose_rollout_with_goal_distance;
    import upr_pkg::*;

    localparam int DRAIN_CYCLES = 200;
    localparam int WATCHDOG_LIMIT = 20000;

    logic        clk;
    logic        rst_n;
    logic        cfg_we;
    logic [2:0]  cfg_index;
    logic [31:0] cfg_data;
    logic        in_valid;
    logic        in_stall;
    logic signed [23:0] linear_speed;
    logic signed [23:0] turn_rate;
    logic        last_step;
    logic        out_valid;
    logic        out_stall;
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic [15:0] heading;
    logic [31:0] goal_distance;
    logic        rollout_end;

    unicycle_pose_rollout_with_goal_distance i_dut (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_cfg_we        (cfg_we),
        .i_cfg_index     (cfg_index),
        .i_cfg_data      (cfg_data),
        .i_in_valid      (in_valid),
        .o_in_stall      (in_stall),
        .i_linear_speed  (linear_speed),
        .i_turn_rate     (turn_rate),
        .i_last_step     (last_step),
        .o_out_valid     (out_valid),
        .i_out_stall     (out_stall),
        .o_pos_x         (pos_x),
        .o_pos_y         (pos_y),
        .o_heading       (heading),
        .o_goal_distance (goal_distance),
        .o_rollout_end   (rollout_end)
    );

    pose_tracker poses;

    // Idle chances in percent for each side; the phase switches them.
    int  send_idle_pct;
    int  recv_idle_pct;
    // While set, the receiver holds stall high regardless of its idle chance.
    bit  hold_off;
    int  requests_sent;
    int  idle_cycles;
    bit  failed;

    always begin
        clk = 1'b1;
        #5;
        clk = 1'b0;
        #5;
    end

    // All checking happens at the rising edge, where each handshake completes.
    always @(posedge clk) begin
        if (rst_n) begin
            if (out_valid && !out_stall) begin
                poses.check_result(pos_x, pos_y, heading, goal_distance, rollout_end);
            end
            if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
                idle_cycles <= 0;
            end else begin
                idle_cycles <= idle_cycles + 1;
            end
        end
    end

    // The receiver picks its stall once per cycle at the falling edge.
    always @(negedge clk) begin
        if (!rst_n) begin
            out_stall <= 1'b0;
        end else begin
            out_stall <= hold_off || ($urandom_range(99) < recv_idle_pct);
        end
    end

    // A long receiver hold-off, counted in cycles here, so that the block fills
    // up and pushes back on its input while the sender keeps offering requests.
    task automatic long_hold_off(int cycles);
        hold_off = 1;
        repeat (cycles) @(negedge clk);
        hold_off = 0;
    endtask

    // Registers change only while the block is idle.
    task automatic write_reg(t_cfg_idx idx, logic [31:0] data);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        poses.write_reg(idx, data);
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    // Offers one request and holds it until the block takes it. Valid stays
    // high straight into the next request when no idle cycle is drawn.
    task automatic send_request(logic [23:0] speed, logic [23:0] rate, bit last);
        while ($urandom_range(99) < send_idle_pct) begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid     <= 1'b1;
        linear_speed <= speed;
        turn_rate    <= rate;
        last_step    <= last;
        @(posedge clk);
        while (in_stall) @(posedge clk);
        poses.note_request(speed, rate, last);
        requests_sent++;
        @(negedge clk);
    endtask

    // Called at the falling edge right after the last request was taken, so
    // valid drops before the next rising edge.
    task automatic wait_drained();
        in_valid <= 1'b0;
        while (poses.pending() != 0) @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
    endtask

    // Random speed: mostly moderate values, sometimes any 24-bit pattern.
    function automatic logic [23:0] pick_speed();
        if ($urandom_range(9) == 0) return 24'($urandom);
        return 24'($signed($urandom_range(2 * 655360)) - 655360);
    endfunction

    function automatic logic [23:0] pick_rate();
        if ($urandom_range(9) == 0) return 24'($urandom);
        return 24'($signed($urandom_range(2 * 262144)) - 262144);
    endfunction

    // Well-formed rollouts of random length with random controls, with the
    // odd very short or very long one.
    task automatic random_rollouts(int count);
        int left_in_run;
        left_in_run = $urandom_range(1, 20);
        for (int n = 0; n < count; n++) begin
            left_in_run--;
            send_request(pick_speed(), pick_rate(), left_in_run <= 0);
            if (left_in_run <= 0) left_in_run = $urandom_range(1, 30);
        end
    endtask

    task automatic random_registers(bit extreme);
        logic [15:0] dt;
        if (extreme) begin
            dt = $urandom_range(1) ? 16'hFFFF : 16'd1;
        end else begin
            dt = 16'($urandom_range(1, 65535));
        end
        write_reg(CFG_STEP_TIME, {16'h0, dt});
        write_reg(CFG_START_X, $urandom_range(3) == 0 ? $urandom : $urandom_range(2000000));
        write_reg(CFG_START_Y, $urandom_range(3) == 0 ? $urandom : $urandom_range(2000000));
        write_reg(CFG_START_HEADING, {16'h0, 16'($urandom)});
        write_reg(CFG_GOAL_X, $urandom_range(3) == 0 ? $urandom : $urandom_range(2000000));
        write_reg(CFG_GOAL_Y, $urandom_range(3) == 0 ? $urandom : $urandom_range(2000000));
    endtask

    // Watchdog: ends the run when nothing moves through the block for too long.
    always @(posedge clk) begin
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("Timeout after %0d cycles with no handshake", idle_cycles);
            $display("Mismatches found");
            $finish;
        end
    end

    initial begin
        poses = new();
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        in_valid = 1'b0;
        linear_speed = '0;
        turn_rate = '0;
        last_step = 1'b0;
        out_stall = 1'b0;
        hold_off = 0;
        send_idle_pct = 14;
        recv_idle_pct = 85;
        requests_sent = 0;
        idle_cycles = 0;
        repeat (12) @(negedge clk);
        rst_n <= 1'b1;

        // Directed part, first from the reset registers: zero controls, the
        // extremes of speed and turn rate, and a rollout that ends and restarts.
        send_request(24'h000000, 24'h000000, 0);
        send_request(24'h7FFFFF, 24'h000000, 0);
        send_request(24'h800000, 24'h7FFFFF, 0);
        send_request(24'h7FFFFF, 24'h800000, 1);
        send_request(24'h010000, 24'h010000, 0);
        send_request(24'hFFFFFF, 24'hFFFFFF, 1);
        send_request(24'h555555, 24'hAAAAAA, 1);
        wait_drained();

        // A goal far away so that the distance saturates, with the largest step.
        write_reg(CFG_STEP_TIME, 32'h0000_FFFF);
        write_reg(CFG_START_X, 32'h8000_0000);
        write_reg(CFG_START_Y, 32'h8000_0000);
        write_reg(CFG_START_HEADING, 32'h0000_FFFF);
        write_reg(CFG_GOAL_X, 32'h7FFF_FFFF);
        write_reg(CFG_GOAL_Y, 32'h7FFF_FFFF);
        send_request(24'h7FFFFF, 24'h7FFFFF, 0);
        send_request(24'h800000, 24'h800000, 0);
        send_request(24'hAAAAAA, 24'h555555, 1);
        // Single-step rollouts from the same start pose and heading, four times over.
        for (int q = 0; q < 4; q++) begin
            send_request(24'h7FFFFF, 24'h000000, 1);
        end
        wait_drained();

        // The smallest step, and register indices the block does not have.
        write_reg(CFG_STEP_TIME, 32'h0000_0001);
        write_reg(CFG_GOAL_X, 32'h0);
        write_reg(CFG_GOAL_Y, 32'h0);
        write_reg(CFG_START_X, 32'h0);
        write_reg(CFG_START_Y, 32'h0);
        write_reg(CFG_START_HEADING, 32'h0000_4000);
        write_reg(t_cfg_idx'(3'd7), 32'hFFFF_FFFF);
        write_reg(t_cfg_idx'(3'd6), 32'h1234_5678);
        send_request(24'h7FFFFF, 24'h7FFFFF, 0);
        send_request(24'h800000, 24'h800000, 1);
        wait_drained();

        // Random phases with varying registers, extremes among them.
        for (int ph = 0; ph < 3; ph++) begin
            send_idle_pct = (ph == 0) ? 14 : (ph == 1) ? 85 : 0;
            recv_idle_pct = (ph == 0) ? 85 : (ph == 1) ? 14 : 0;
            for (int k = 0; k < 4; k++) begin
                random_registers(k == 0);
                if (ph == 2 && k == 1) begin
                    fork
                        long_hold_off(600);
                        random_rollouts(60);
                    join
                end else begin
                    random_rollouts(171);
                end
                wait_drained();
            end
        end

        failed = poses.mismatches != 0 || poses.pending() != 0;
        $display("Covered %0d requests and %0d results over three idle patterns,",
                 requests_sent, poses.results_seen);
        $display("with register sets from the smallest to the largest step.");
        if (!failed) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end
endmodule
